// ===== sv/pgxhp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PGX header parser: parse phases, skip modes, error codes,
// byte constants and the state and result structs. No dependencies.
package pgxhp_pkg;

    // Bytes that the header grammar looks for
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int unsigned NUM_W   = 16;
    localparam int unsigned ALIGN_W = 3;   // allocation rounds to 8 bits

    typedef enum logic [3:0] {
        PH_MAGIC1      = 4'd0,
        PH_MAGIC2      = 4'd1,
        PH_ORDER1      = 4'd2,
        PH_ORDER2      = 4'd3,
        PH_SIGN        = 4'd4,
        PH_BITS_START  = 4'd5,
        PH_BITS_DIGITS = 4'd6,
        PH_COLS_START  = 4'd7,
        PH_COLS_DIGITS = 4'd8,
        PH_ROWS_START  = 4'd9,
        PH_ROWS_DIGITS = 4'd10
    } pgxhp_phase_t;

    typedef enum logic [1:0] {
        SK_BLANKS      = 2'd0,
        SK_COMMENT     = 2'd1,
        SK_BLANKS_ONLY = 2'd2
    } pgxhp_skip_t;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_MAGIC      = 3'd1,
        ERR_ORDER      = 3'd2,
        ERR_SIGN       = 3'd3,
        ERR_NO_NUMBER  = 3'd4,
        ERR_STREAM_END = 3'd5,
        ERR_TOO_LARGE  = 3'd6
    } pgxhp_err_t;

    typedef struct packed {
        pgxhp_phase_t      phase;
        pgxhp_skip_t       skip;
        logic [NUM_W-1:0]  acc;
        logic [NUM_W-1:0]  bits;
        logic [NUM_W-1:0]  cols;
        logic              little_endian;
        logic              is_signed;
        logic [7:0]        first_letter;
    } pgxhp_state_t;

    typedef struct packed {
        logic              valid;
        pgxhp_err_t        err;
        logic              little_endian;
        logic              is_signed;
        logic [NUM_W-1:0]  bit_depth;
        logic [NUM_W-1:0]  bits_allocated;
        logic [NUM_W-1:0]  column_count;
        logic [NUM_W-1:0]  row_count;
    } pgxhp_result_t;

    localparam pgxhp_state_t STATE_RESET = '{
        phase:         PH_MAGIC1,
        skip:          SK_BLANKS,
        acc:           '0,
        bits:          '0,
        cols:          '0,
        little_endian: 1'b0,
        is_signed:     1'b0,
        first_letter:  '0
    };

endpackage

// ===== sv/pgxhp_step.sv =====
`timescale 1ns / 1ps
// Single-byte parse step: next parser state and the optional result item.
// Depends on pgxhp_pkg.
module pgxhp_step (
    input  pgxhp_pkg::pgxhp_state_t  cur,
    input  logic [7:0]               data_byte,
    input  logic                     end_of_stream,
    output pgxhp_pkg::pgxhp_state_t  nxt,
    output pgxhp_pkg::pgxhp_result_t res
);

    logic                    is_blank;
    logic                    is_digit;
    logic [3:0]              dval;
    logic                    tok;
    pgxhp_pkg::pgxhp_skip_t  skip_tok;
    logic [19:0]             acc_x10;
    logic                    fin;
    pgxhp_pkg::pgxhp_err_t   fin_err;
    logic [16:0]             bits_round;

    assign is_blank = (data_byte == pgxhp_pkg::CH_SPACE) || (data_byte == pgxhp_pkg::CH_TAB)
                   || (data_byte == pgxhp_pkg::CH_LF);
    assign is_digit = (data_byte >= pgxhp_pkg::CH_ZERO) && (data_byte <= pgxhp_pkg::CH_NINE);
    assign dval     = data_byte[3:0];
    assign acc_x10  = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {16'd0, dval};

    // Token gate: skip blanks and at most one comment line before a token
    always_comb begin
        tok      = 1'b0;
        skip_tok = cur.skip;
        if (cur.skip == pgxhp_pkg::SK_COMMENT) begin
            if (data_byte == pgxhp_pkg::CH_LF) begin
                skip_tok = pgxhp_pkg::SK_BLANKS_ONLY;
            end
        end else if (is_blank) begin
            skip_tok = cur.skip;
        end else if (cur.skip == pgxhp_pkg::SK_BLANKS && data_byte == pgxhp_pkg::CH_HASH) begin
            skip_tok = pgxhp_pkg::SK_COMMENT;
        end else begin
            skip_tok = pgxhp_pkg::SK_BLANKS;
            tok      = 1'b1;
        end
    end

    // Next state
    always_comb begin
        nxt     = cur;
        fin     = 1'b0;
        fin_err = pgxhp_pkg::ERR_OK;
        if (end_of_stream) begin
            fin     = 1'b1;
            fin_err = pgxhp_pkg::ERR_STREAM_END;
        end else begin
            case (cur.phase)
                pgxhp_pkg::PH_MAGIC1, pgxhp_pkg::PH_ORDER1: begin
                    nxt.skip = skip_tok;
                    if (tok) begin
                        nxt.first_letter = data_byte;
                        nxt.phase = (cur.phase == pgxhp_pkg::PH_MAGIC1) ?
                                    pgxhp_pkg::PH_MAGIC2 : pgxhp_pkg::PH_ORDER2;
                    end
                end
                pgxhp_pkg::PH_MAGIC2: begin
                    if (cur.first_letter != pgxhp_pkg::CH_P || data_byte != pgxhp_pkg::CH_G) begin
                        fin     = 1'b1;
                        fin_err = pgxhp_pkg::ERR_MAGIC;
                    end else begin
                        nxt.phase = pgxhp_pkg::PH_ORDER1;
                    end
                end
                pgxhp_pkg::PH_ORDER2: begin
                    if (cur.first_letter == pgxhp_pkg::CH_L && data_byte == pgxhp_pkg::CH_M) begin
                        nxt.little_endian = 1'b1;
                        nxt.is_signed     = 1'b0;
                        nxt.phase         = pgxhp_pkg::PH_SIGN;
                    end else if (cur.first_letter == pgxhp_pkg::CH_M
                                 && data_byte == pgxhp_pkg::CH_L) begin
                        nxt.little_endian = 1'b0;
                        nxt.is_signed     = 1'b0;
                        nxt.phase         = pgxhp_pkg::PH_SIGN;
                    end else begin
                        fin     = 1'b1;
                        fin_err = pgxhp_pkg::ERR_ORDER;
                    end
                end
                pgxhp_pkg::PH_SIGN: begin
                    nxt.skip = skip_tok;
                    if (tok) begin
                        if (data_byte == pgxhp_pkg::CH_PLUS || data_byte == pgxhp_pkg::CH_MINUS) begin
                            nxt.is_signed = cur.is_signed | (data_byte == pgxhp_pkg::CH_MINUS);
                            nxt.phase     = pgxhp_pkg::PH_BITS_START;
                        end else if (is_digit) begin
                            nxt.acc   = {12'd0, dval};
                            nxt.phase = pgxhp_pkg::PH_BITS_DIGITS;
                        end else begin
                            fin     = 1'b1;
                            fin_err = pgxhp_pkg::ERR_SIGN;
                        end
                    end
                end
                pgxhp_pkg::PH_BITS_START, pgxhp_pkg::PH_COLS_START,
                pgxhp_pkg::PH_ROWS_START: begin
                    nxt.skip = skip_tok;
                    if (tok) begin
                        if (!is_digit) begin
                            fin     = 1'b1;
                            fin_err = pgxhp_pkg::ERR_NO_NUMBER;
                        end else begin
                            nxt.acc   = {12'd0, dval};
                            nxt.phase = pgxhp_pkg::pgxhp_phase_t'(cur.phase + 4'd1);
                        end
                    end
                end
                pgxhp_pkg::PH_BITS_DIGITS, pgxhp_pkg::PH_COLS_DIGITS,
                pgxhp_pkg::PH_ROWS_DIGITS: begin
                    if (is_digit) begin
                        if (acc_x10[19:16] != 4'd0) begin
                            fin     = 1'b1;
                            fin_err = pgxhp_pkg::ERR_TOO_LARGE;
                        end else begin
                            nxt.acc = acc_x10[15:0];
                        end
                    end else if (cur.phase == pgxhp_pkg::PH_ROWS_DIGITS) begin
                        fin     = 1'b1;
                        fin_err = pgxhp_pkg::ERR_OK;
                    end else begin
                        if (cur.phase == pgxhp_pkg::PH_BITS_DIGITS) begin
                            nxt.bits  = cur.acc;
                            nxt.phase = pgxhp_pkg::PH_COLS_START;
                        end else begin
                            nxt.cols  = cur.acc;
                            nxt.phase = pgxhp_pkg::PH_ROWS_START;
                        end
                        nxt.acc  = '0;
                        nxt.skip = pgxhp_pkg::SK_BLANKS;
                    end
                end
                default: begin
                    nxt = pgxhp_pkg::STATE_RESET;
                end
            endcase
        end
        if (fin) begin
            nxt = pgxhp_pkg::STATE_RESET;
        end
    end

    assign bits_round = {1'b0, cur.bits} + 17'd7;

    // Result item
    always_comb begin
        res       = '0;
        res.valid = fin;
        res.err   = fin_err;
        if (fin && fin_err == pgxhp_pkg::ERR_OK) begin
            res.little_endian  = cur.little_endian;
            res.is_signed      = cur.is_signed;
            res.bit_depth      = cur.bits;
            res.bits_allocated = {bits_round[15:pgxhp_pkg::ALIGN_W],
                                  {pgxhp_pkg::ALIGN_W{1'b0}}};
            res.column_count   = cur.cols;
            res.row_count      = cur.acc;
        end
    end

endmodule

// ===== sv/pgx_header_parser_core.sv =====
`timescale 1ns / 1ps
// Top level of the PGX header parser: input register, parse step, result register.
// Depends on pgxhp_pkg and pgxhp_step.

// The block takes one header byte per item on the s_ channel and emits at most one
// result item on the m_ channel for each header: when "PG", the byte order, the
// optional sign and the bit depth, column and row numbers have all been read, or at
// the first error. Throughput is one byte per clock while s_ready is high. An
// accepted byte is held in the input register while the step logic parses it; the
// result register loads when that byte advances, and m_valid rises with it. The
// step logic computes the next parse state combinationally, and the state register
// loads it when the byte advances. Bytes that finish no header keep flowing while
// a result waits; only a byte that finishes the next header is held in the input
// register, with s_ready low, until m_ready takes the waiting result. After every
// result the parser is back in its start state and the next byte begins a new
// header. On error, all fields other than m_error_code are zero.
module pgx_header_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_error_code,
    output logic        m_little_endian,
    output logic        m_is_signed,
    output logic [15:0] m_bit_depth,
    output logic [15:0] m_bits_allocated,
    output logic [15:0] m_column_count,
    output logic [15:0] m_row_count
);

    // Input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_eos_reg;

    // Parser state and result register
    pgxhp_pkg::pgxhp_state_t  state_reg;
    pgxhp_pkg::pgxhp_state_t  state_next;
    pgxhp_pkg::pgxhp_result_t step_res;
    pgxhp_pkg::pgxhp_result_t res_reg;
    logic                     m_valid_reg;
    logic                     m_valid_next;

    logic advance;

    // Advance the held byte when it makes no result, or when the result slot is
    // free or being emptied
    assign advance = in_valid_reg && (!step_res.valid || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance && step_res.valid) begin
            m_valid_next = 1'b1;
        end
    end

    pgxhp_step u_step (
        .cur           (state_reg),
        .data_byte     (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .nxt           (state_next),
        .res           (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= pgxhp_pkg::STATE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: the input byte captures on accept, the result when a result advances; both hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eos_reg  <= s_end_of_stream;
        end
        if (advance && step_res.valid) begin
            res_reg <= step_res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_error_code     = res_reg.err;
    assign m_little_endian  = res_reg.little_endian;
    assign m_is_signed      = res_reg.is_signed;
    assign m_bit_depth      = res_reg.bit_depth;
    assign m_bits_allocated = res_reg.bits_allocated;
    assign m_column_count   = res_reg.column_count;
    assign m_row_count      = res_reg.row_count;

endmodule

// ===== sv/pgxhp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the PGX header parser, bound to the top level.
// Depends on pgxhp_pkg and pgx_header_parser_core.
module pgxhp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_error_code,
    input logic        m_little_endian,
    input logic        m_is_signed,
    input logic [15:0] m_bit_depth,
    input logic [15:0] m_bits_allocated,
    input logic [15:0] m_column_count,
    input logic [15:0] m_row_count
);

    logic        res_ok;
    logic [15:0] alloc_pad;

    assign res_ok    = m_error_code == pgxhp_pkg::ERR_OK;
    assign alloc_pad = m_bits_allocated - m_bit_depth;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_error_code))
        else $error("result item dropped or changed while stalled");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_error_code != 3'd7)
        else $error("undefined error code");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !res_ok |-> !m_little_endian && !m_is_signed && m_bit_depth == 16'd0
            && m_bits_allocated == 16'd0 && m_column_count == 16'd0 && m_row_count == 16'd0)
        else $error("error result carries nonzero fields");

    a_alloc_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && res_ok |-> m_bits_allocated[2:0] == 3'd0)
        else $error("bits allocated not a whole number of bytes");

    a_alloc_round: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && res_ok |-> alloc_pad <= 16'd7)
        else $error("bits allocated not the bit depth rounded up");

endmodule

bind pgx_header_parser_core pgxhp_checker u_pgxhp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_error_code     (m_error_code),
    .m_little_endian  (m_little_endian),
    .m_is_signed      (m_is_signed),
    .m_bit_depth      (m_bit_depth),
    .m_bits_allocated (m_bits_allocated),
    .m_column_count   (m_column_count),
    .m_row_count      (m_row_count)
);
